// ===== design/spg_pkg.sv =====
`timescale 1ns / 1ps

package spg_pkg;

    localparam int CHANNEL_COUNT    = 11;
    localparam int GROUP_COUNT      = 4;
    localparam int TICKS_PER_SECOND = 2000000;

    // Quotient width of a division of the tick rate by a nonzero value.
    localparam int TICK_W     = $clog2(TICKS_PER_SECOND + 1);
    localparam int DIV_CNT_W  = $clog2(TICK_W + 1);

    localparam int ACTION_W   = 2;
    localparam int CH_W       = 4;
    localparam int PULSE_W    = 16;
    localparam int CLAMP_W    = 14;
    localparam int FREQ_W     = 15;
    localparam int TOP_W      = 16;
    localparam int CMP_W      = 16;
    localparam int PIN_W      = 11;
    localparam int REG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CLAMP_W-1:0] RESET_MIN_PULSE = CLAMP_W'(900);
    localparam logic [CLAMP_W-1:0] RESET_MAX_PULSE = CLAMP_W'(2100);
    localparam logic [FREQ_W-1:0]  RESET_FREQ      = FREQ_W'(50);
    localparam logic [TOP_W-1:0]   RESET_TOP       = TOP_W'(TICKS_PER_SECOND / 50);
    localparam logic [PIN_W-1:0]   RESET_ENABLE    = PIN_W'(255);
    localparam logic [CMP_W-1:0]   RESET_COMPARE   = {CMP_W{1'b1}};

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_TICK  = 2'd2
    } action_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_MIN_PULSE = 3'd0,
        REG_MAX_PULSE = 3'd1,
        REG_FREQ_A    = 3'd2,
        REG_FREQ_B    = 3'd3,
        REG_FREQ_D    = 3'd4,
        REG_TOP_C     = 3'd5,
        REG_ENABLE    = 3'd6
    } reg_index_t;

    typedef enum logic [1:0] {
        GRP_A = 2'd0,
        GRP_B = 2'd1,
        GRP_C = 2'd2,
        GRP_D = 2'd3
    } group_t;

    typedef struct packed {
        logic   valid;
        group_t grp;
    } chan_map_t;

    // Configuration as seen by the datapath, plus the divider busy flag.
    typedef struct packed {
        logic [CLAMP_W-1:0]                 min_pulse;
        logic [CLAMP_W-1:0]                 max_pulse;
        logic [GROUP_COUNT-1:0][TOP_W-1:0]  top;
        logic [GROUP_COUNT-1:0][FREQ_W-1:0] freq_rb;
        logic [PIN_W-1:0]                   pin_enable;
        logic                               busy;
    } cfg_state_t;

    typedef struct packed {
        logic [FREQ_W-1:0] readback_us;
        logic [FREQ_W-1:0] group_freq_hz;
        logic [PIN_W-1:0]  pin_levels;
        logic              channel_valid;
    } result_t;

    function automatic chan_map_t chan_map(input logic [CH_W-1:0] ch);
        chan_map_t m;
        m.valid = 1'b1;
        case (ch)
            4'd0, 4'd1, 4'd8:  m.grp = GRP_A;
            4'd2, 4'd3, 4'd9:  m.grp = GRP_B;
            4'd4, 4'd5:        m.grp = GRP_C;
            4'd6, 4'd7, 4'd10: m.grp = GRP_D;
            default:
            begin
                m.valid = 1'b0;
                m.grp   = GRP_A;
            end
        endcase
        if (32'(ch) >= CHANNEL_COUNT)
        begin
            m.valid = 1'b0;
        end
        return m;
    endfunction

    function automatic logic [TOP_W-1:0] sat_top(input logic [TICK_W-1:0] q);
        return (q > TICK_W'({TOP_W{1'b1}})) ? {TOP_W{1'b1}} : q[TOP_W-1:0];
    endfunction

    function automatic logic [FREQ_W-1:0] sat_freq(input logic [TICK_W-1:0] q);
        return (q > TICK_W'({FREQ_W{1'b1}})) ? {FREQ_W{1'b1}} : q[FREQ_W-1:0];
    endfunction

endpackage

// ===== design/spg_ifs.sv =====
`timescale 1ns / 1ps

interface spg_req_if;
    logic                          valid;
    logic                          ready;
    logic [spg_pkg::ACTION_W-1:0]  action;
    logic [spg_pkg::CH_W-1:0]      channel;
    logic [spg_pkg::PULSE_W-1:0]   pulse_us;

    modport source (output valid, action, channel, pulse_us, input ready);
    modport sink   (input valid, action, channel, pulse_us, output ready);
endinterface

interface spg_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [spg_pkg::FREQ_W-1:0]   readback_us;
    logic [spg_pkg::FREQ_W-1:0]   group_freq_hz;
    logic [spg_pkg::PIN_W-1:0]    pin_levels;
    logic                         channel_valid;

    modport source (output valid, readback_us, group_freq_hz, pin_levels, channel_valid,
                    input ready);
    modport sink   (input valid, readback_us, group_freq_hz, pin_levels, channel_valid,
                    output ready);
endinterface

interface spg_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [spg_pkg::REG_IDX_W-1:0]   index;
    logic [spg_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/servo_pwm_channel_generator.sv =====
`timescale 1ns / 1ps

// Channel  Role    Fields                                              Transfer
// req      input   action, channel, pulse_us                           valid && ready
// rsp      output  readback_us, group_freq_hz, pin_levels, channel_valid  valid && ready
// cfg      input   index, data                                         valid && ready
//
// One item per clock while req is not held off: state updates and the result are
// computed in the cycle of the transfer, and the result is registered for rsp.
// A write to a frequency register runs the shared one-bit-per-cycle divider twice;
// a write to the group C top runs it once. req and cfg are held off meanwhile.
// Reset is asynchronous and restores all configuration registers, compares and counters.
// A stalled rsp is absorbed by a skid register; req drops ready when it is full or busy.
module servo_pwm_channel_generator
(
    input  logic      clk,
    input  logic      rst_n,
    spg_req_if.sink   req,
    spg_rsp_if.source rsp,
    spg_cfg_if.sink   cfg
);

    spg_pkg::cfg_state_t cfg_state;

    spg_config u_config
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .state_out (cfg_state)
    );

    spg_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_state (cfg_state)
    );

endmodule

// ===== design/spg_divider.sv =====
`timescale 1ns / 1ps

// Restoring divider of the constant tick rate by a 16-bit divisor, one quotient
// bit per cycle. A zero divisor yields an all-ones quotient.
module spg_divider
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [spg_pkg::TOP_W-1:0]    divisor,
    output logic                         done,
    output logic [spg_pkg::TICK_W-1:0]   quotient
);

    logic [spg_pkg::TOP_W-1:0]     div_reg;
    logic [spg_pkg::TOP_W-1:0]     rem_reg,  rem_next;
    logic [spg_pkg::TICK_W-1:0]    quo_reg,  quo_next;
    logic [spg_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [spg_pkg::TOP_W:0]       shifted;
    logic [spg_pkg::TOP_W:0]       diff;
    logic                          ge;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[spg_pkg::TICK_W-1]};
        diff     = shifted - {1'b0, div_reg};
        ge       = shifted >= {1'b0, div_reg};
        rem_next = ge ? diff[spg_pkg::TOP_W-1:0] : shifted[spg_pkg::TOP_W-1:0];
        quo_next = {quo_reg[spg_pkg::TICK_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= spg_pkg::DIV_CNT_W'(spg_pkg::TICK_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == spg_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= spg_pkg::TICK_W'(spg_pkg::TICKS_PER_SECOND);
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== design/spg_config.sv =====
`timescale 1ns / 1ps

// Register file plus the sequencer that derives group tops and frequency
// readbacks through the shared divider.
module spg_config
(
    input  logic                 clk,
    input  logic                 rst_n,
    spg_cfg_if.sink              cfg,
    output spg_pkg::cfg_state_t  state_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_TOP_DIV,
        S_FREQ_DIV
    } seq_state_t;

    seq_state_t                                          state_reg;
    spg_pkg::group_t                                     grp_reg;
    logic [spg_pkg::CLAMP_W-1:0]                         min_reg;
    logic [spg_pkg::CLAMP_W-1:0]                         max_reg;
    logic [spg_pkg::PIN_W-1:0]                           enable_reg;
    logic [spg_pkg::GROUP_COUNT-1:0][spg_pkg::TOP_W-1:0]  top_reg;
    logic [spg_pkg::GROUP_COUNT-1:0][spg_pkg::FREQ_W-1:0] freq_reg;
    logic                                                div_start_reg;
    logic [spg_pkg::TOP_W-1:0]                           divisor_reg;
    logic                                                div_done;
    logic [spg_pkg::TICK_W-1:0]                          quotient;
    logic                                                write;

    spg_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .divisor  (divisor_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign cfg.ready = (state_reg == S_IDLE);
    assign write     = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            grp_reg       <= spg_pkg::GRP_A;
            min_reg       <= spg_pkg::RESET_MIN_PULSE;
            max_reg       <= spg_pkg::RESET_MAX_PULSE;
            enable_reg    <= spg_pkg::RESET_ENABLE;
            top_reg       <= {spg_pkg::GROUP_COUNT{spg_pkg::RESET_TOP}};
            freq_reg      <= {spg_pkg::GROUP_COUNT{spg_pkg::RESET_FREQ}};
            div_start_reg <= 1'b0;
            divisor_reg   <= '0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (write)
                    begin
                        unique case (cfg.index)
                            spg_pkg::REG_MIN_PULSE: min_reg <= cfg.data[spg_pkg::CLAMP_W-1:0];
                            spg_pkg::REG_MAX_PULSE: max_reg <= cfg.data[spg_pkg::CLAMP_W-1:0];
                            spg_pkg::REG_ENABLE:    enable_reg <= cfg.data[spg_pkg::PIN_W-1:0];
                            spg_pkg::REG_FREQ_A, spg_pkg::REG_FREQ_B, spg_pkg::REG_FREQ_D:
                            begin
                                if (cfg.index == spg_pkg::REG_FREQ_A)
                                begin
                                    grp_reg <= spg_pkg::GRP_A;
                                end
                                else if (cfg.index == spg_pkg::REG_FREQ_B)
                                begin
                                    grp_reg <= spg_pkg::GRP_B;
                                end
                                else
                                begin
                                    grp_reg <= spg_pkg::GRP_D;
                                end
                                divisor_reg   <= {1'b0, cfg.data[spg_pkg::FREQ_W-1:0]};
                                div_start_reg <= 1'b1;
                                state_reg     <= S_TOP_DIV;
                            end
                            spg_pkg::REG_TOP_C:
                            begin
                                grp_reg                   <= spg_pkg::GRP_C;
                                top_reg[spg_pkg::GRP_C]   <= cfg.data[spg_pkg::TOP_W-1:0];
                                divisor_reg               <= cfg.data[spg_pkg::TOP_W-1:0];
                                div_start_reg             <= 1'b1;
                                state_reg                 <= S_FREQ_DIV;
                            end
                            default: ;
                        endcase
                    end
                end
                S_TOP_DIV:
                begin
                    if (div_done)
                    begin
                        top_reg[grp_reg] <= spg_pkg::sat_top(quotient);
                        divisor_reg      <= spg_pkg::sat_top(quotient);
                        div_start_reg    <= 1'b1;
                        state_reg        <= S_FREQ_DIV;
                    end
                end
                S_FREQ_DIV:
                begin
                    if (div_done)
                    begin
                        freq_reg[grp_reg] <= spg_pkg::sat_freq(quotient);
                        state_reg         <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        state_out.min_pulse  = min_reg;
        state_out.max_pulse  = max_reg;
        state_out.top        = top_reg;
        state_out.freq_rb    = freq_reg;
        state_out.pin_enable = enable_reg;
        state_out.busy       = (state_reg != S_IDLE);
    end

endmodule

// ===== design/spg_core.sv =====
`timescale 1ns / 1ps

// Compare registers, group counters and pin logic, updated once per accepted
// item, with a result register backed by a skid register.
module spg_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    spg_req_if.sink              req,
    spg_rsp_if.source            rsp,
    input  spg_pkg::cfg_state_t  cfg_state
);

    logic [spg_pkg::CMP_W-1:0] cmp_reg [spg_pkg::CHANNEL_COUNT];
    logic [spg_pkg::CMP_W-1:0] cmp_next [spg_pkg::CHANNEL_COUNT];
    logic [spg_pkg::TOP_W-1:0] cnt_reg [spg_pkg::GROUP_COUNT];
    logic [spg_pkg::TOP_W-1:0] cnt_next [spg_pkg::GROUP_COUNT];

    spg_pkg::result_t          out_reg;
    spg_pkg::result_t          skid_reg;
    spg_pkg::result_t          result;
    logic                      out_valid_reg;
    logic                      skid_valid_reg;
    logic                      accept;
    spg_pkg::chan_map_t        map;
    spg_pkg::chan_map_t        pin_map;
    logic [spg_pkg::CLAMP_W-1:0] clamped;

    assign req.ready = !cfg_state.busy && !skid_valid_reg;
    assign accept    = req.valid && req.ready;
    assign map       = spg_pkg::chan_map(req.channel);

    always_comb
    begin
        // When the bounds are reversed, a pulse above max gets max and any other pulse gets min.
        if (req.pulse_us > spg_pkg::PULSE_W'(cfg_state.max_pulse))
        begin
            clamped = cfg_state.max_pulse;
        end
        else if (req.pulse_us < spg_pkg::PULSE_W'(cfg_state.min_pulse))
        begin
            clamped = cfg_state.min_pulse;
        end
        else
        begin
            clamped = req.pulse_us[spg_pkg::CLAMP_W-1:0];
        end
    end

    always_comb
    begin
        cmp_next             = cmp_reg;
        cnt_next             = cnt_reg;
        result.readback_us   = '0;
        result.channel_valid = map.valid;
        result.group_freq_hz = map.valid ? cfg_state.freq_rb[map.grp] : '0;
        if (accept)
        begin
            unique case (req.action)
                spg_pkg::ACT_WRITE:
                begin
                    for (int i = 0; i < spg_pkg::CHANNEL_COUNT; i++)
                    begin
                        if (map.valid && (req.channel == spg_pkg::CH_W'(i)))
                        begin
                            cmp_next[i] = spg_pkg::CMP_W'({clamped, 1'b0});
                        end
                    end
                end
                spg_pkg::ACT_READ:
                begin
                    if (map.valid)
                    begin
                        result.readback_us = cmp_reg[req.channel][spg_pkg::CMP_W-1:1];
                    end
                end
                spg_pkg::ACT_TICK:
                begin
                    for (int g = 0; g < spg_pkg::GROUP_COUNT; g++)
                    begin
                        cnt_next[g] = (cnt_reg[g] >= cfg_state.top[g]) ? '0
                                                                       : cnt_reg[g] + 1'b1;
                    end
                end
                default: ;
            endcase
        end
        result.pin_levels = '0;
        for (int i = 0; i < spg_pkg::CHANNEL_COUNT; i++)
        begin
            pin_map = spg_pkg::chan_map(spg_pkg::CH_W'(i));
            result.pin_levels[i] = cfg_state.pin_enable[i]
                                   && (cnt_next[pin_map.grp] <= cmp_next[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < spg_pkg::CHANNEL_COUNT; i++)
            begin
                cmp_reg[i] <= spg_pkg::RESET_COMPARE;
            end
            for (int g = 0; g < spg_pkg::GROUP_COUNT; g++)
            begin
                cnt_reg[g] <= '0;
            end
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            cmp_reg <= cmp_next;
            cnt_reg <= cnt_next;
            if (accept)
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (!out_valid_reg || rsp.ready)
            begin
                out_valid_reg  <= skid_valid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (!out_valid_reg || rsp.ready)
            begin
                out_reg <= result;
            end
            else
            begin
                skid_reg <= result;
            end
        end
        else if ((!out_valid_reg || rsp.ready) && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.readback_us   = out_reg.readback_us;
    assign rsp.group_freq_hz = out_reg.group_freq_hz;
    assign rsp.pin_levels    = out_reg.pin_levels;
    assign rsp.channel_valid = out_reg.channel_valid;

endmodule

// ===== design/spg_checker.sv =====
`timescale 1ns / 1ps

module spg_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             req_valid,
    input logic                             req_ready,
    input logic                             rsp_valid,
    input logic                             rsp_ready,
    input logic [spg_pkg::FREQ_W-1:0]       rsp_readback_us,
    input logic [spg_pkg::FREQ_W-1:0]       rsp_group_freq_hz,
    input logic [spg_pkg::PIN_W-1:0]        rsp_pin_levels,
    input logic                             rsp_channel_valid,
    input logic                             cfg_valid,
    input logic                             cfg_ready,
    input logic [spg_pkg::REG_IDX_W-1:0]    cfg_index
);

    // A held result must not change until it is taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_readback_us)
            && $stable(rsp_group_freq_hz) && $stable(rsp_pin_levels)
            && $stable(rsp_channel_valid))
        else $error("rsp payload changed while stalled");

    // An invalid channel reports neither a readback nor a frequency.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_channel_valid |-> rsp_readback_us == '0 && rsp_group_freq_hz == '0)
        else $error("invalid channel returned nonzero fields");

    // A frequency or group C top write starts the divider, which holds off new items.
    a_div_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && (cfg_index == spg_pkg::REG_FREQ_A
            || cfg_index == spg_pkg::REG_FREQ_B || cfg_index == spg_pkg::REG_FREQ_D
            || cfg_index == spg_pkg::REG_TOP_C)
        |=> !req_ready && !cfg_ready)
        else $error("items accepted while the divider runs");

    // A result can only appear after an input transfer.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready))
        else $error("result without an input transfer");

endmodule

bind servo_pwm_channel_generator spg_checker u_spg_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_readback_us   (rsp.readback_us),
    .rsp_group_freq_hz (rsp.group_freq_hz),
    .rsp_pin_levels    (rsp.pin_levels),
    .rsp_channel_valid (rsp.channel_valid),
    .cfg_valid         (cfg.valid),
    .cfg_ready         (cfg.ready),
    .cfg_index         (cfg.index)
);

// ===== tb/servo_pwm_channel_generator_tb.sv =====
`timescale 1ns / 1ps

module servo_pwm_channel_generator_tb;

    localparam logic [spg_pkg::ACTION_W-1:0] ACT_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 10;
    localparam int ITEMS_PER_PHASE = 150;

    // Expected-result store plus an item-level model of the servo timer groups.
    class servo_scoreboard;
        logic [spg_pkg::CLAMP_W-1:0] min_pulse;
        logic [spg_pkg::CLAMP_W-1:0] max_pulse;
        logic [spg_pkg::PIN_W-1:0]   enable;
        logic [spg_pkg::CMP_W-1:0]   compare [spg_pkg::CHANNEL_COUNT];
        logic [spg_pkg::TOP_W-1:0]   counter [spg_pkg::GROUP_COUNT];
        logic [spg_pkg::TOP_W-1:0]   top [spg_pkg::GROUP_COUNT];
        logic [spg_pkg::FREQ_W-1:0]  freq_rb [spg_pkg::GROUP_COUNT];
        spg_pkg::result_t            pending [$];
        int                          errors;

        function new();
            min_pulse = spg_pkg::RESET_MIN_PULSE;
            max_pulse = spg_pkg::RESET_MAX_PULSE;
            enable    = spg_pkg::RESET_ENABLE;
            errors    = 0;
            for (int i = 0; i < spg_pkg::CHANNEL_COUNT; i++)
            begin
                compare[i] = 16'hFFFF;
            end
            for (int g = 0; g < spg_pkg::GROUP_COUNT; g++)
            begin
                counter[g] = '0;
                top[g]     = 16'd40000;
                freq_rb[g] = 15'd50;
            end
        endfunction

        // Returns the timer group of a channel, or -1 for an unused channel number.
        function int group_of(logic [spg_pkg::CH_W-1:0] ch);
            case (ch)
                4'd0, 4'd1, 4'd8:  return int'(spg_pkg::GRP_A);
                4'd2, 4'd3, 4'd9:  return int'(spg_pkg::GRP_B);
                4'd4, 4'd5:        return int'(spg_pkg::GRP_C);
                4'd6, 4'd7, 4'd10: return int'(spg_pkg::GRP_D);
                default:           return -1;
            endcase
        endfunction

        function logic [spg_pkg::TOP_W-1:0] top_for_freq(int unsigned freq);
            int unsigned q;
            if (freq == 0)
            begin
                return 16'hFFFF;
            end
            q = spg_pkg::TICKS_PER_SECOND / freq;
            return (q > 32'hFFFF) ? 16'hFFFF : q[spg_pkg::TOP_W-1:0];
        endfunction

        function logic [spg_pkg::FREQ_W-1:0] freq_for_top(int unsigned t);
            int unsigned q;
            if (t == 0)
            begin
                return 15'h7FFF;
            end
            q = spg_pkg::TICKS_PER_SECOND / t;
            return (q > 32'h7FFF) ? 15'h7FFF : q[spg_pkg::FREQ_W-1:0];
        endfunction

        function void write_reg(spg_pkg::reg_index_t idx, logic [spg_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                spg_pkg::REG_MIN_PULSE: min_pulse = data[spg_pkg::CLAMP_W-1:0];
                spg_pkg::REG_MAX_PULSE: max_pulse = data[spg_pkg::CLAMP_W-1:0];
                spg_pkg::REG_FREQ_A:
                begin
                    top[spg_pkg::GRP_A]     = top_for_freq(32'(data[spg_pkg::FREQ_W-1:0]));
                    freq_rb[spg_pkg::GRP_A] = freq_for_top(32'(top[spg_pkg::GRP_A]));
                end
                spg_pkg::REG_FREQ_B:
                begin
                    top[spg_pkg::GRP_B]     = top_for_freq(32'(data[spg_pkg::FREQ_W-1:0]));
                    freq_rb[spg_pkg::GRP_B] = freq_for_top(32'(top[spg_pkg::GRP_B]));
                end
                spg_pkg::REG_FREQ_D:
                begin
                    top[spg_pkg::GRP_D]     = top_for_freq(32'(data[spg_pkg::FREQ_W-1:0]));
                    freq_rb[spg_pkg::GRP_D] = freq_for_top(32'(top[spg_pkg::GRP_D]));
                end
                spg_pkg::REG_TOP_C:
                begin
                    top[spg_pkg::GRP_C]     = data;
                    freq_rb[spg_pkg::GRP_C] = freq_for_top(32'(data));
                end
                spg_pkg::REG_ENABLE: enable = data[spg_pkg::PIN_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_item(logic [spg_pkg::ACTION_W-1:0] act,
                                logic [spg_pkg::CH_W-1:0] ch,
                                logic [spg_pkg::PULSE_W-1:0] pulse);
            int               g;
            int unsigned      p;
            spg_pkg::result_t r;
            g = group_of(ch);
            r = '0;
            if (act == spg_pkg::ACT_WRITE && g >= 0)
            begin
                // The max bound is tested first; with crossed bounds it wins only above max, else min.
                p = 32'(pulse);
                if (p > 32'(max_pulse))
                begin
                    p = 32'(max_pulse);
                end
                else if (p < 32'(min_pulse))
                begin
                    p = 32'(min_pulse);
                end
                compare[ch] = 16'(p << 1);
            end
            else if (act == spg_pkg::ACT_READ && g >= 0)
            begin
                r.readback_us = compare[ch][spg_pkg::CMP_W-1:1];
            end
            else if (act == spg_pkg::ACT_TICK)
            begin
                for (int i = 0; i < spg_pkg::GROUP_COUNT; i++)
                begin
                    counter[i] = (counter[i] >= top[i]) ? '0 : counter[i] + 16'd1;
                end
            end
            if (g >= 0)
            begin
                r.group_freq_hz = freq_rb[g];
                r.channel_valid = 1'b1;
            end
            for (int i = 0; i < spg_pkg::CHANNEL_COUNT; i++)
            begin
                r.pin_levels[i] = enable[i] && (counter[group_of(4'(i))] <= compare[i]);
            end
            pending.push_back(r);
        endfunction

        function void check_result(spg_pkg::result_t got);
            spg_pkg::result_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("[%0t] result with nothing pending: rb=%0d freq=%0d pins=%03h vld=%0b",
                             $realtime, got.readback_us, got.group_freq_hz, got.pin_levels,
                             got.channel_valid);
                end
                return;
            end
            want = pending.pop_front();
            if (got.readback_us !== want.readback_us || got.group_freq_hz !== want.group_freq_hz
                || got.pin_levels !== want.pin_levels
                || got.channel_valid !== want.channel_valid)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("[%0t] mismatch: want rb=%0d freq=%0d pins=%03h vld=%0b",
                             $realtime, want.readback_us, want.group_freq_hz,
                             want.pin_levels, want.channel_valid);
                    $display("                 got  rb=%0d freq=%0d pins=%03h vld=%0b",
                             got.readback_us, got.group_freq_hz, got.pin_levels,
                             got.channel_valid);
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sink_ready = 1'b0;
    int   cycles = 0;
    int   burst_left = 0;
    int   stall_mode = 0;
    servo_scoreboard sb;

    spg_req_if req_ch();
    spg_rsp_if rsp_ch();
    spg_cfg_if cfg_ch();

    assign rsp_ch.ready = sink_ready;

    servo_pwm_channel_generator i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // The response side cycles through stall styles, including long free-flowing spans.
    always @(posedge clk)
    begin
        if (cycles % 64 == 0)
        begin
            stall_mode <= int'($urandom_range(0, 3));
        end
        case (stall_mode)
            0: sink_ready <= 1'b1;
            1: sink_ready <= ($urandom_range(0, 1) == 1);
            2: sink_ready <= ($urandom_range(0, 3) == 0);
            default: sink_ready <= (cycles % 5 != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                sb.check_result({rsp_ch.readback_us, rsp_ch.group_freq_hz,
                                 rsp_ch.pin_levels, rsp_ch.channel_valid});
            end
            if (req_ch.valid && req_ch.ready)
            begin
                sb.note_item(req_ch.action, req_ch.channel, req_ch.pulse_us);
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                sb.write_reg(spg_pkg::reg_index_t'(cfg_ch.index), cfg_ch.data);
            end
        end
    end

    task automatic send_item(input logic [spg_pkg::ACTION_W-1:0] act,
                             input logic [spg_pkg::CH_W-1:0] ch,
                             input logic [spg_pkg::PULSE_W-1:0] pulse);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
            burst_left = int'($urandom_range(1, 30));
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        req_ch.valid    <= 1'b1;
        req_ch.action   <= act;
        req_ch.channel  <= ch;
        req_ch.pulse_us <= pulse;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        burst_left--;
    endtask

    task automatic send_random();
        int                           pick;
        logic [spg_pkg::ACTION_W-1:0] act;
        logic [spg_pkg::CH_W-1:0]     ch;
        logic [spg_pkg::PULSE_W-1:0]  pulse;
        pick = int'($urandom_range(0, 99));
        if (pick < 50)
        begin
            act = spg_pkg::ACT_TICK;
        end
        else if (pick < 72)
        begin
            act = spg_pkg::ACT_WRITE;
        end
        else if (pick < 95)
        begin
            act = spg_pkg::ACT_READ;
        end
        else
        begin
            act = ACT_NONE;
        end
        ch    = ($urandom_range(0, 9) == 0) ? spg_pkg::CH_W'($urandom_range(11, 15))
                                            : spg_pkg::CH_W'($urandom_range(0, 10));
        pulse = ($urandom_range(0, 1) == 1) ? spg_pkg::PULSE_W'($urandom_range(0, 200))
                                            : spg_pkg::PULSE_W'($urandom_range(0, 65535));
        send_item(act, ch, pulse);
    endtask

    // Drops the request valid and waits until every pending response has come back.
    task automatic drain();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic configure(input logic [6:0] which,
                             input logic [6:0][spg_pkg::CFG_DATA_W-1:0] vals);
        for (int i = 0; i < 7; i++)
        begin
            if (which[i])
            begin
                cfg_ch.valid <= 1'b1;
                cfg_ch.index <= spg_pkg::reg_index_t'(i);
                cfg_ch.data  <= vals[i];
                @(posedge clk);
                while (!cfg_ch.ready)
                begin
                    @(posedge clk);
                end
            end
        end
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        logic [6:0][spg_pkg::CFG_DATA_W-1:0] regs;
        sb = new();
        req_ch.valid    <= 1'b0;
        req_ch.action   <= spg_pkg::ACT_WRITE;
        req_ch.channel  <= '0;
        req_ch.pulse_us <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= spg_pkg::REG_MIN_PULSE;
        cfg_ch.data     <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: clamping at both ends, an unwritten compare, invalid channels.
        send_item(spg_pkg::ACT_WRITE, 4'd0, 16'd0);
        send_item(spg_pkg::ACT_WRITE, 4'd1, 16'hFFFF);
        send_item(spg_pkg::ACT_WRITE, 4'd8, 16'd1500);
        send_item(spg_pkg::ACT_READ, 4'd0, 16'd0);
        send_item(spg_pkg::ACT_READ, 4'd1, 16'd0);
        send_item(spg_pkg::ACT_READ, 4'd3, 16'd0);
        send_item(spg_pkg::ACT_WRITE, 4'd11, 16'd1000);
        send_item(spg_pkg::ACT_READ, 4'd15, 16'd0);
        send_item(ACT_NONE, 4'd4, 16'hAAAA);
        send_item(spg_pkg::ACT_TICK, 4'd10, 16'h5555);
        send_item(spg_pkg::ACT_TICK, 4'd12, 16'd0);
        drain();

        // Crossed clamp bounds, zero and too-low frequencies, a fast group D and a zero top.
        regs[spg_pkg::REG_MIN_PULSE] = 16'd2000;
        regs[spg_pkg::REG_MAX_PULSE] = 16'd1000;
        regs[spg_pkg::REG_FREQ_A]    = 16'd0;
        regs[spg_pkg::REG_FREQ_B]    = 16'd30;
        regs[spg_pkg::REG_FREQ_D]    = 16'd32767;
        regs[spg_pkg::REG_TOP_C]     = 16'd0;
        regs[spg_pkg::REG_ENABLE]    = 16'h07FF;
        configure(7'h7F, regs);
        send_item(spg_pkg::ACT_WRITE, 4'd2, 16'd1500);
        send_item(spg_pkg::ACT_WRITE, 4'd9, 16'd500);
        send_item(spg_pkg::ACT_READ, 4'd2, 16'd0);
        send_item(spg_pkg::ACT_READ, 4'd9, 16'd0);
        send_item(spg_pkg::ACT_READ, 4'd4, 16'd0);
        send_item(spg_pkg::ACT_READ, 4'd0, 16'd0);
        send_item(spg_pkg::ACT_TICK, 4'd1, 16'd0);
        send_item(spg_pkg::ACT_TICK, 4'd5, 16'd0);
        send_item(spg_pkg::ACT_READ, 4'd6, 16'd0);
        drain();

        // A tiny group C period so channel 5 visibly wraps, and a lowered group D top.
        regs[spg_pkg::REG_MIN_PULSE] = 16'd0;
        regs[spg_pkg::REG_MAX_PULSE] = 16'd16383;
        regs[spg_pkg::REG_FREQ_D]    = 16'd20000;
        regs[spg_pkg::REG_TOP_C]     = 16'd3;
        configure(7'b0110011, regs);
        send_item(spg_pkg::ACT_WRITE, 4'd5, 16'd1);
        repeat (4) send_item(spg_pkg::ACT_TICK, 4'd5, 16'd0);

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:
                begin
                    regs[spg_pkg::REG_MIN_PULSE] = 16'd0;
                    regs[spg_pkg::REG_MAX_PULSE] = 16'd60;
                    regs[spg_pkg::REG_FREQ_A]    = 16'd20000;
                    regs[spg_pkg::REG_FREQ_B]    = 16'd31;
                    regs[spg_pkg::REG_FREQ_D]    = 16'd16000;
                    regs[spg_pkg::REG_TOP_C]     = 16'd100;
                    regs[spg_pkg::REG_ENABLE]    = 16'($urandom_range(0, 2047));
                end
                1:
                begin
                    regs[spg_pkg::REG_MIN_PULSE] = 16'd16383;
                    regs[spg_pkg::REG_MAX_PULSE] = 16'd16383;
                    regs[spg_pkg::REG_FREQ_A]    = 16'd31;
                    regs[spg_pkg::REG_FREQ_B]    = 16'd20000;
                    regs[spg_pkg::REG_FREQ_D]    = 16'd31;
                    regs[spg_pkg::REG_TOP_C]     = 16'd65535;
                    regs[spg_pkg::REG_ENABLE]    = 16'd0;
                end
                2:
                begin
                    regs[spg_pkg::REG_MIN_PULSE] = 16'd0;
                    regs[spg_pkg::REG_MAX_PULSE] = 16'd0;
                    regs[spg_pkg::REG_FREQ_A]    = 16'd32767;
                    regs[spg_pkg::REG_FREQ_B]    = 16'd25000;
                    regs[spg_pkg::REG_FREQ_D]    = 16'd32767;
                    regs[spg_pkg::REG_TOP_C]     = 16'd0;
                    regs[spg_pkg::REG_ENABLE]    = 16'h07FF;
                end
                3:
                begin
                    regs[spg_pkg::REG_MIN_PULSE] = 16'($urandom_range(0, 100));
                    regs[spg_pkg::REG_MAX_PULSE] = 16'($urandom_range(0, 150));
                    regs[spg_pkg::REG_FREQ_A]    = 16'($urandom_range(15000, 32767));
                    regs[spg_pkg::REG_FREQ_B]    = 16'($urandom_range(15000, 32767));
                    regs[spg_pkg::REG_FREQ_D]    = 16'($urandom_range(15000, 32767));
                    regs[spg_pkg::REG_TOP_C]     = 16'($urandom_range(0, 200));
                    regs[spg_pkg::REG_ENABLE]    = 16'($urandom_range(0, 2047));
                end
                default:
                begin
                    regs[spg_pkg::REG_MIN_PULSE] = 16'($urandom_range(0, 16383));
                    regs[spg_pkg::REG_MAX_PULSE] = 16'($urandom_range(0, 16383));
                    regs[spg_pkg::REG_FREQ_A]    = 16'($urandom_range(0, 32767));
                    regs[spg_pkg::REG_FREQ_B]    = 16'($urandom_range(0, 32767));
                    regs[spg_pkg::REG_FREQ_D]    = 16'($urandom_range(0, 32767));
                    regs[spg_pkg::REG_TOP_C]     = 16'($urandom_range(0, 65535));
                    regs[spg_pkg::REG_ENABLE]    = 16'($urandom_range(0, 2047));
                end
            endcase
            drain();
            configure(7'h7F, regs);
            repeat (ITEMS_PER_PHASE) send_random();
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
